// ===== src/hvd_pkg.sv =====
// Shared types, constants and constant functions for the haversine distance pipeline.
// Used by every module under src; it depends on nothing else.
package hvd_pkg;

  typedef logic [31:0]        turn_t;
  typedef logic signed [63:0] q60_t;
  typedef logic [32:0]        aq_t;

  localparam int NumLanes = 4;

  // Lane order at the output of the coordinate converter.
  localparam int TurnLat1 = 0;
  localparam int TurnLon1 = 1;
  localparam int TurnLat2 = 2;
  localparam int TurnLon2 = 3;

  // Lane order in the cosine pipeline.
  localparam int CosLat1 = 0;
  localparam int CosLat2 = 1;
  localparam int CosDLat = 2;
  localparam int CosDLon = 3;

  // Lanes of the square root unit.
  localparam int SqLaneA   = 0;
  localparam int SqLaneB   = 1;
  localparam int SqLanes   = 2;
  localparam int SqrtSteps = 32;

  // One turn is 3.6e9 units; the factor 1024 is taken out of the divisor.
  localparam int          TurnRemW         = 22;
  localparam int          TurnNumW         = 54;
  localparam int          TurnStages       = 8;
  localparam int          TurnBitsPerStage = 4;
  localparam logic [21:0] TurnDiv          = 22'd3515625;
  localparam logic [21:0] TurnBias         = 22'd1757812;

  localparam logic [31:0] PiQ60Hi    = 32'h3243F6A8;
  localparam logic [31:0] PiQ60Lo    = 32'h885A308D;
  localparam q60_t        CordicKQ60 = 64'sd700114967507363238;
  localparam q60_t        OneQ60     = 64'sh1000_0000_0000_0000;
  localparam q60_t        Pi4Q60     = 64'sh0C90_FDAA_2216_8C23;

  localparam aq_t AqOne = 33'h1_0000_0000;

  localparam int          RadiusW     = 23;
  localparam logic [22:0] RadiusReset = 23'd6371000;
  localparam int          DistW       = 35;
  localparam logic [34:0] DistMax     = 35'd26353589000;
  localparam logic [10:0] DistScale   = 11'd2000;

  // Floor of 2^n / d by long division, for building the arctangent table.
  function automatic logic [63:0] hvd_pow2_div(input int n, input int d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int j = 60; j >= 0; j--) begin
      r = {r[62:0], (j == n)};
      if (r >= 64'(d)) begin
        r    = r - 64'(d);
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-idx in Q60 radians from the alternating series.
  function automatic q60_t hvd_atan_entry(input int idx);
    q60_t sum;
    int   e;
    logic neg;
    if (idx == 0) begin
      return Pi4Q60;
    end
    sum = '0;
    neg = 1'b0;
    for (int k = 0; k <= 30; k++) begin
      e = idx * (2 * k + 1);
      if (e <= 60) begin
        if (neg) begin
          sum = sum - signed'(hvd_pow2_div(60 - e, 2 * k + 1));
        end else begin
          sum = sum + signed'(hvd_pow2_div(60 - e, 2 * k + 1));
        end
      end
      neg = ~neg;
    end
    return sum;
  endfunction

endpackage

// ===== src/haversine_distance_top.sv =====
// Haversine great-circle distance engine: takes one pair of points per clock while in_stall_o
// is low and returns the distance in millimetres on a sphere of programmable radius. Fully
// pipelined, one word per cycle sustained while out_stall_i is low. Most of the depth lies in
// the two CORDIC chains (one iteration per stage) and the 32-stage square root. A two-entry
// output buffer lets the pipeline take one more word while the output is stalled; in_stall_o
// rises only when both entries are full. The radius register is written through cfg_we_i and
// should only change while the pipeline is empty.
// Depends on hvd_pkg and the hvd_* submodules.
module haversine_distance_top #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [30:0]          first_lat_i,
  input  logic signed [31:0]          first_lon_i,
  input  logic signed [30:0]          second_lat_i,
  input  logic signed [31:0]          second_lon_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hvd_pkg::DistW-1:0]   distance_mm_o,
  input  logic                        cfg_we_i,
  input  logic [hvd_pkg::RadiusW-1:0] cfg_wdata_i
);
  import hvd_pkg::*;

  logic [RadiusW-1:0] radius_q;
  logic               en;
  logic               turn_vld;
  turn_t              turn [NumLanes];
  logic               cos_vld;
  q60_t               cosv [NumLanes];
  logic               hav_vld;
  aq_t                aq;
  logic               sq_vld;
  aq_t                root [SqLanes];
  logic               dist_vld;
  logic [DistW-1:0]   dist_word;
  logic               arrive;
  logic               take;
  logic               out_vld_q, out_vld_d;
  logic               skid_vld_q, skid_vld_d;
  logic [DistW-1:0]   out_data_q, out_data_d;
  logic [DistW-1:0]   skid_data_q, skid_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign en = ~skid_vld_q;

  hvd_turn u_turn (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .first_lat_i  (first_lat_i),
    .first_lon_i  (first_lon_i),
    .second_lat_i (second_lat_i),
    .second_lon_i (second_lon_i),
    .valid_o      (turn_vld),
    .turn_o       (turn)
  );

  hvd_cos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (turn_vld),
    .turn_i  (turn),
    .valid_o (cos_vld),
    .cos_o   (cosv)
  );

  hvd_hav u_hav (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cos_vld),
    .cos_i   (cosv),
    .valid_o (hav_vld),
    .aq_o    (aq)
  );

  hvd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hav_vld),
    .aq_i    (aq),
    .valid_o (sq_vld),
    .root_o  (root)
  );

  hvd_atan #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_atan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_vld),
    .root_i   (root),
    .radius_i (radius_q),
    .valid_o  (dist_vld),
    .dist_o   (dist_word)
  );

  assign arrive = en & dist_vld;
  assign take   = out_vld_q & ~out_stall_i;

  always_comb begin
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    skid_vld_d  = skid_vld_q;
    skid_data_d = skid_data_q;
    if (skid_vld_q) begin
      if (take) begin
        out_data_d = skid_data_q;
        skid_vld_d = 1'b0;
      end
    end else if (arrive) begin
      if (!out_vld_q || take) begin
        out_vld_d  = 1'b1;
        out_data_d = dist_word;
      end else begin
        skid_vld_d  = 1'b1;
        skid_data_d = dist_word;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign in_stall_o    = skid_vld_q;
  assign out_valid_o   = out_vld_q;
  assign distance_mm_o = out_data_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("Skid entry filled while the output register was free.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("Skid entry holds a word while the output register is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q <= DistMax))
    else $error("Output distance exceeds the saturation limit.");
`endif

endmodule

// ===== src/hvd_turn.sv =====
// Converts the four coordinates from 1e-7 degree units to binary fractions of a turn.
// Pipelined constant divider, four quotient bits per stage; depends on hvd_pkg.
module hvd_turn (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [30:0]   first_lat_i,
  input  logic signed [31:0]   first_lon_i,
  input  logic signed [30:0]   second_lat_i,
  input  logic signed [31:0]   second_lon_i,
  output logic                 valid_o,
  output hvd_pkg::turn_t       turn_o [hvd_pkg::NumLanes]
);
  import hvd_pkg::*;

  logic signed [31:0]    coord   [NumLanes];
  logic [31:0]           mag     [NumLanes];
  logic [TurnNumW-1:0]   num_d   [NumLanes];
  logic [TurnRemW-1:0]   rem_q   [TurnStages+1][NumLanes];
  logic [31:0]           low_q   [TurnStages+1][NumLanes];
  logic [31:0]           quo_q   [TurnStages+1][NumLanes];
  logic                  neg_q   [TurnStages+1][NumLanes];
  logic [TurnStages:0]   vld_q;
  logic                  out_vld_q;
  turn_t                 turn_q  [NumLanes];

  assign coord[TurnLat1] = 32'(first_lat_i);
  assign coord[TurnLon1] = first_lon_i;
  assign coord[TurnLat2] = 32'(second_lat_i);
  assign coord[TurnLon2] = second_lon_i;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      mag[l]   = coord[l][31] ? (~coord[l] + 32'd1) : coord[l];
      num_d[l] = {mag[l], 22'd0} + TurnNumW'(TurnBias);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        rem_q[0][l] <= num_d[l][TurnNumW-1:32];
        low_q[0][l] <= num_d[l][31:0];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= coord[l][31];
      end
    end
  end

  for (genvar s = 0; s < TurnStages; s++) begin : g_div
    logic [TurnRemW-1:0] rem_w [NumLanes];
    logic [31:0]         low_w [NumLanes];
    logic [31:0]         quo_w [NumLanes];

    always_comb begin
      logic [TurnRemW:0] trial;
      trial = '0;
      for (int l = 0; l < NumLanes; l++) begin
        rem_w[l] = rem_q[s][l];
        low_w[l] = low_q[s][l];
        quo_w[l] = quo_q[s][l];
        for (int b = 0; b < TurnBitsPerStage; b++) begin
          trial    = {rem_w[l], low_w[l][31]};
          low_w[l] = {low_w[l][30:0], 1'b0};
          if (trial >= {1'b0, TurnDiv}) begin
            rem_w[l] = TurnRemW'(trial - {1'b0, TurnDiv});
            quo_w[l] = {quo_w[l][30:0], 1'b1};
          end else begin
            rem_w[l] = trial[TurnRemW-1:0];
            quo_w[l] = {quo_w[l][30:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < NumLanes; l++) begin
          rem_q[s+1][l] <= rem_w[l];
          low_q[s+1][l] <= low_w[l];
          quo_q[s+1][l] <= quo_w[l];
          neg_q[s+1][l] <= neg_q[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        turn_q[l] <= neg_q[TurnStages][l] ? (32'd0 - quo_q[TurnStages][l])
                                          : quo_q[TurnStages][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[TurnStages-1:0], valid_i};
      out_vld_q <= vld_q[TurnStages];
    end
  end

  assign valid_o = out_vld_q;
  assign turn_o  = turn_q;

endmodule

// ===== src/hvd_cos.sv =====
// Four-lane pipelined rotation CORDIC giving the cosines of two latitudes and two deltas.
// One CORDIC iteration per stage; depends on hvd_pkg.
module hvd_cos #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  hvd_pkg::turn_t turn_i [hvd_pkg::NumLanes],
  output logic           valid_o,
  output hvd_pkg::q60_t  cos_o  [hvd_pkg::NumLanes]
);
  import hvd_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  turn_t        ang_q  [NumLanes];
  logic [61:0]  ph_q   [NumLanes];
  logic [61:0]  pl_q   [NumLanes];
  logic [1:0]   quad_p_q [NumLanes];
  q60_t         x_q    [N+1][NumLanes];
  q60_t         y_q    [N+1][NumLanes];
  q60_t         z_q    [N+1][NumLanes];
  logic [1:0]   quad_q [N+1][NumLanes];
  q60_t         cos_q  [NumLanes];
  logic [N+2:0] vld_q;
  logic         out_vld_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q[CosLat1] <= turn_i[TurnLat1];
      ang_q[CosLat2] <= turn_i[TurnLat2];
      ang_q[CosDLat] <= turn_i[TurnLat2] - turn_i[TurnLat1];
      ang_q[CosDLon] <= turn_i[TurnLon2] - turn_i[TurnLon1];
      for (int l = 0; l < NumLanes; l++) begin
        ph_q[l]     <= ang_q[l][29:0] * PiQ60Hi;
        pl_q[l]     <= ang_q[l][29:0] * PiQ60Lo;
        quad_p_q[l] <= ang_q[l][31:30];
        x_q[0][l]    <= CordicKQ60;
        y_q[0][l]    <= '0;
        z_q[0][l]    <= signed'(64'({ph_q[l], 1'b0}) + 64'(pl_q[l][61:31]));
        quad_q[0][l] <= quad_p_q[l];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam q60_t AtanI = hvd_atan_entry(i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < NumLanes; l++) begin
          if (!z_q[i][l][63]) begin
            x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] - AtanI;
          end else begin
            x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] + AtanI;
          end
          quad_q[i+1][l] <= quad_q[i][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        unique case (quad_q[N][l])
          2'd0: cos_q[l] <= x_q[N][l];
          2'd1: cos_q[l] <= -y_q[N][l];
          2'd2: cos_q[l] <= -x_q[N][l];
          2'd3: cos_q[l] <= y_q[N][l];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[N+1:0], valid_i};
      out_vld_q <= vld_q[N+2];
    end
  end

  assign valid_o = out_vld_q;
  assign cos_o   = cos_q;

endmodule

// ===== src/hvd_hav.sv =====
// Forms the haversine term a from the four cosines and rounds it to unsigned Q1.32.
// Four stages: two multiplies, the sum, then rounding and clamping; depends on hvd_pkg.
module hvd_hav (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  hvd_pkg::q60_t cos_i [hvd_pkg::NumLanes],
  output logic          valid_o,
  output hvd_pkg::aq_t  aq_o
);
  import hvd_pkg::*;

  logic signed [33:0] c1h;
  logic signed [33:0] c2h;
  logic signed [33:0] s2h_d;
  q60_t               s1_d;
  q60_t               s1_q;
  logic signed [33:0] s2h_q;
  logic signed [67:0] p1_q;
  logic signed [33:0] prod;
  q60_t               s1b_q;
  logic signed [67:0] tp_q;
  q60_t               a61_q;
  logic [63:0]        rnd;
  aq_t                aq_d;
  aq_t                aq_q;
  logic [2:0]         vld_q;
  logic               out_vld_q;

  assign c1h   = 34'(cos_i[CosLat1] >>> 29);
  assign c2h   = 34'(cos_i[CosLat2] >>> 29);
  assign s1_d  = (OneQ60 - cos_i[CosDLat]) >>> 1;
  assign s2h_d = 34'((OneQ60 - cos_i[CosDLon]) >>> 30);
  assign prod  = 34'(p1_q >>> 31);
  assign rnd   = 64'(a61_q) + (64'd1 << 28);

  always_comb begin
    if (a61_q[63] || (a61_q == '0)) begin
      aq_d = '0;
    end else if (rnd[63:29] > 35'(AqOne)) begin
      aq_d = AqOne;
    end else begin
      aq_d = rnd[61:29];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2h_q <= s2h_d;
      p1_q  <= c1h * c2h;
      s1b_q <= s1_q;
      tp_q  <= prod * s2h_q;
      a61_q <= (s1b_q <<< 1) + 64'(tp_q >>> 1);
      aq_q  <= aq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[1:0], valid_i};
      out_vld_q <= vld_q[2];
    end
  end

  assign valid_o = out_vld_q;
  assign aq_o    = aq_q;

endmodule

// ===== src/hvd_sqrt.sv =====
// Two-lane pipelined shift-subtract square root giving sqrt(a) and sqrt(1 - a) in Q1.32.
// One result bit per stage; depends on hvd_pkg.
module hvd_sqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  hvd_pkg::aq_t aq_i,
  output logic         valid_o,
  output hvd_pkg::aq_t root_o [hvd_pkg::SqLanes]
);
  import hvd_pkg::*;

  aq_t                vin    [SqLanes];
  logic [63:0]        n_q    [SqrtSteps+1][SqLanes];
  logic [63:0]        res_q  [SqrtSteps+1][SqLanes];
  logic               full_q [SqrtSteps+1][SqLanes];
  aq_t                root_q [SqLanes];
  logic [SqrtSteps:0] vld_q;
  logic               out_vld_q;

  assign vin[SqLaneA] = aq_i;
  assign vin[SqLaneB] = AqOne - aq_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < SqLanes; l++) begin
        n_q[0][l]    <= {vin[l][31:0], 32'd0};
        res_q[0][l]  <= '0;
        full_q[0][l] <= vin[l][32];
      end
    end
  end

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
    localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * s);
    logic [63:0] trial [SqLanes];

    always_comb begin
      for (int l = 0; l < SqLanes; l++) begin
        trial[l] = res_q[s][l] + StepBit;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < SqLanes; l++) begin
          if (n_q[s][l] >= trial[l]) begin
            n_q[s+1][l]   <= n_q[s][l] - trial[l];
            res_q[s+1][l] <= (res_q[s][l] >> 1) + StepBit;
          end else begin
            n_q[s+1][l]   <= n_q[s][l];
            res_q[s+1][l] <= res_q[s][l] >> 1;
          end
          full_q[s+1][l] <= full_q[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < SqLanes; l++) begin
        root_q[l] <= full_q[SqrtSteps][l] ? AqOne : {1'b0, res_q[SqrtSteps][l][31:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[SqrtSteps-1:0], valid_i};
      out_vld_q <= vld_q[SqrtSteps];
    end
  end

  assign valid_o = out_vld_q;
  assign root_o  = root_q;

endmodule

// ===== src/hvd_atan.sv =====
// Pipelined vectoring CORDIC for the central angle, then scaling by the radius to millimetres.
// Ends in a rounded multiply by 2000 and saturation; depends on hvd_pkg.
module hvd_atan #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  hvd_pkg::aq_t                root_i [hvd_pkg::SqLanes],
  input  logic [hvd_pkg::RadiusW-1:0] radius_i,
  output logic                        valid_o,
  output logic [hvd_pkg::DistW-1:0]   dist_o
);
  import hvd_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  q60_t         x_q [N+1];
  q60_t         y_q [N+1];
  q60_t         z_q [N+1];
  logic [36:0]  th36;
  logic [59:0]  m_q;
  logic [34:0]  hi_q;
  logic [46:0]  lo_sum;
  logic [10:0]  lo_q;
  logic [35:0]  d_sum;
  logic [DistW-1:0] dist_q;
  logic [N+2:0] vld_q;
  logic         out_vld_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= signed'(64'(root_i[SqLaneB]) << 20);
      y_q[0] <= signed'(64'(root_i[SqLaneA]) << 20);
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam q60_t AtanI = hvd_atan_entry(i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][63]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + AtanI;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - AtanI;
        end
      end
    end
  end

  assign th36   = z_q[N][63] ? '0 : 37'(z_q[N] >>> 24);
  assign lo_sum = (m_q[35:0] * DistScale) + (47'd1 << 35);
  assign d_sum  = {1'b0, hi_q} + 36'(lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= th36 * radius_i;
      hi_q   <= m_q[59:36] * DistScale;
      lo_q   <= lo_sum[46:36];
      dist_q <= (d_sum > 36'(DistMax)) ? DistMax : d_sum[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[N+1:0], valid_i};
      out_vld_q <= vld_q[N+2];
    end
  end

  assign valid_o = out_vld_q;
  assign dist_o  = dist_q;

endmodule
